// ===== rtl/gslc_pkg.sv =====
// Shared types, constants and helpers of the glyph slot LRU cache.
// No dependencies; every other file of the block but gslc_ram imports this package.
package gslc_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CHAR_W     = 32;
  localparam int DIM_W      = 12;
  localparam int STAMP_W    = 32;
  localparam int REQ_TYPE_W = 2;
  localparam int SLOT_IDX_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [STAMP_W-1:0] STAMP_MAX     = '1;
  localparam logic [STAMP_W-1:0] COUNTER_RESET = STAMP_W'(1);
  localparam logic [DIM_W-1:0]   BITMAP_RESET  = DIM_W'(32);

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_GET      = 2'd0,
    REQ_PRECACHE = 2'd1,
    REQ_UNCACHE  = 2'd2,
    REQ_QUERY    = 2'd3
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BITMAP_WIDTH  = 1'd0,
    CFG_BITMAP_HEIGHT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic               clear;
    logic               load;
    logic [SLOT_AW-1:0] idx;
  } scan_ctl_t;

  // Running result of one pass over the slots.
  typedef struct packed {
    logic               match_found;
    logic [SLOT_AW-1:0] match_idx;
    logic               free_found;
    logic [SLOT_AW-1:0] free_idx;
    logic               lru_found;
    logic [SLOT_AW-1:0] lru_idx;
    logic [STAMP_W-1:0] min_stamp;
    key_t               lru_key;
  } scan_res_t;

  typedef struct packed {
    logic                  ok;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  evicted;
    logic [CHAR_W-1:0]     evicted_char;
    logic [DIM_W-1:0]      evicted_width;
    logic [DIM_W-1:0]      evicted_height;
  } rsp_t;

  // Low bits of a slot number as reported on the result channel.
  function automatic logic [SLOT_IDX_W-1:0] slot_index_out(input logic [SLOT_AW-1:0] idx);
    logic [SLOT_AW+SLOT_IDX_W-1:0] wide;
    wide = {{SLOT_IDX_W{1'b0}}, idx};
    return wide[SLOT_IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/gslc_req_if.sv =====
// Request channel of the glyph slot LRU cache: valid/ready plus request fields.
// Depends on gslc_pkg.
interface gslc_req_if;
  import gslc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [CHAR_W-1:0]     char_code;
  logic [DIM_W-1:0]      req_width;
  logic [DIM_W-1:0]      req_height;

  modport source(output valid, req_type, char_code, req_width, req_height, input ready);
  modport sink(input valid, req_type, char_code, req_width, req_height, output ready);
endinterface

// ===== rtl/gslc_rsp_if.sv =====
// Result channel of the glyph slot LRU cache: valid/ready plus result fields.
// Depends on gslc_pkg.
interface gslc_rsp_if;
  import gslc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic                  hit;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  evicted;
  logic [CHAR_W-1:0]     evicted_char;
  logic [DIM_W-1:0]      evicted_width;
  logic [DIM_W-1:0]      evicted_height;

  modport source(output valid, ok, hit, slot_index, evicted, evicted_char, evicted_width,
                 evicted_height, input ready);
  modport sink(input valid, ok, hit, slot_index, evicted, evicted_char, evicted_width,
               evicted_height, output ready);
endinterface

// ===== rtl/gslc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gslc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gslc_scan.sv =====
// Shared compare unit: takes one slot per cycle while load is set, and tracks the
// key match, the first free slot and the first slot with the smallest stamp. Uses gslc_pkg.
module gslc_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  gslc_pkg::scan_ctl_t ctl,
  input  gslc_pkg::key_t      key,
  input  gslc_pkg::slot_t     slot,
  output gslc_pkg::scan_res_t res
);
  import gslc_pkg::*;

  scan_res_t res_r, res_nxt;
  logic      is_free, is_match, is_less;

  assign is_free  = (slot.stamp == '0);
  assign is_match = !is_free && (slot.key == key);
  assign is_less  = !is_free && (slot.stamp < res_r.min_stamp);

  always_comb begin
    res_nxt = res_r;
    if (ctl.clear) begin
      res_nxt           = '0;
      res_nxt.min_stamp = STAMP_MAX;
    end else if (ctl.load) begin
      if (is_free && !res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = ctl.idx;
      end
      if (is_match && !res_r.match_found) begin
        res_nxt.match_found = 1'b1;
        res_nxt.match_idx   = ctl.idx;
      end
      // strict compare keeps the first slot among equal stamps
      if (is_less) begin
        res_nxt.lru_found = 1'b1;
        res_nxt.lru_idx   = ctl.idx;
        res_nxt.min_stamp = slot.stamp;
        res_nxt.lru_key   = slot.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r           <= '0;
      res_r.min_stamp <= STAMP_MAX;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/glyph_slot_lru_cache_unit.sv =====
// Glyph slot LRU cache: fully associative slots keyed by character code and
// clamped glyph size, with per-slot usage stamps for least-recent replacement.
// Depends on gslc_pkg, gslc_req_if, gslc_rsp_if, gslc_ram and gslc_scan.
//
// One request at a time. Each request reads all SLOTS slot entries from the
// slot RAM, one per cycle through its single read port, into one compare unit,
// then passes through a flush state and a decide state that writes back and
// builds the result; decide waits while an earlier result has not been taken. The
// result register lets the next request start while a result waits to be taken.
// Slot valid bits are cleared by reset, so no clearing pass is needed.
module glyph_slot_lru_cache_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  gslc_req_if.sink                         in_req,
  gslc_rsp_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [gslc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gslc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gslc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   bw_r, bh_r;
  logic [STAMP_W-1:0] use_cnt_r;
  req_kind_t          kind_r;
  key_t               key_r;
  logic [SLOT_AW-1:0] cnt_r;
  logic               pend_r;
  logic [SLOT_AW-1:0] pend_idx_r;
  logic [SLOTS-1:0]   valid_r;
  logic               out_valid_r;
  rsp_t               rsp_r, rsp_nxt;

  logic               accept, advance, last_issue;
  logic               ram_we, ram_re;
  logic [SLOT_AW-1:0] ram_waddr;
  slot_t              ram_wdata;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_t              slot_rd;
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;
  logic [DIM_W-1:0]   clamp_w, clamp_h;
  logic               bump_cnt;

  assign accept     = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign advance    = (state_r == ST_DECIDE) && (!out_valid_r || out_rsp.ready);
  assign last_issue = (cnt_r == SLOT_AW'(SLOTS - 1));

  assign clamp_w = (in_req.req_width < bw_r) ? in_req.req_width : bw_r;
  assign clamp_h = (in_req.req_height < bh_r) ? in_req.req_height : bh_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (last_issue) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_DECIDE;
      ST_DECIDE: if (advance) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (state_r == ST_SCAN) begin
        cnt_r <= last_issue ? '0 : cnt_r + SLOT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r;
    if (accept) begin
      kind_r          <= req_kind_t'(in_req.req_type);
      key_r.char_code <= in_req.char_code;
      key_r.width     <= clamp_w;
      key_r.height    <= clamp_h;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= BITMAP_RESET;
      bh_r <= BITMAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BITMAP_WIDTH:  bw_r <= cfg_data[DIM_W-1:0];
        CFG_BITMAP_HEIGHT: bh_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // slot storage
  assign ram_re = (state_r == ST_SCAN);

  gslc_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(cnt_r),
    .rdata(ram_rdata)
  );

  // never-written slots read as free
  assign slot_rd = valid_r[pend_idx_r] ? slot_t'(ram_rdata) : '0;

  assign scan_ctl.clear = accept;
  assign scan_ctl.load  = pend_r;
  assign scan_ctl.idx   = pend_idx_r;

  gslc_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (scan_ctl),
    .key  (key_r),
    .slot (slot_rd),
    .res  (scan_res)
  );

  // decide, write back and build the result
  always_comb begin
    rsp_nxt           = '0;
    rsp_nxt.hit       = scan_res.match_found;
    ram_we            = 1'b0;
    ram_waddr         = scan_res.match_idx;
    ram_wdata.key     = key_r;
    ram_wdata.stamp   = use_cnt_r;
    bump_cnt          = 1'b0;
    unique case (kind_r)
      REQ_GET, REQ_PRECACHE: begin
        priority if (scan_res.match_found) begin
          ram_waddr = scan_res.match_idx;
          rsp_nxt.ok = 1'b1;
        end else if (scan_res.free_found) begin
          ram_waddr = scan_res.free_idx;
          rsp_nxt.ok = 1'b1;
        end else if (scan_res.lru_found) begin
          ram_waddr              = scan_res.lru_idx;
          rsp_nxt.ok             = 1'b1;
          rsp_nxt.evicted        = 1'b1;
          rsp_nxt.evicted_char   = scan_res.lru_key.char_code;
          rsp_nxt.evicted_width  = scan_res.lru_key.width;
          rsp_nxt.evicted_height = scan_res.lru_key.height;
        end else begin
          rsp_nxt.ok = 1'b0;
        end
        ram_we = rsp_nxt.ok && advance;
        if (rsp_nxt.ok) begin
          rsp_nxt.slot_index = slot_index_out(ram_waddr);
        end
        bump_cnt = rsp_nxt.ok && advance && (kind_r == REQ_GET);
      end
      REQ_UNCACHE: begin
        rsp_nxt.ok = scan_res.match_found;
        ram_wdata  = '0;
        ram_we     = scan_res.match_found && advance;
      end
      REQ_QUERY: begin
        rsp_nxt.ok = scan_res.match_found;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      use_cnt_r   <= COUNTER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (bump_cnt) begin
        use_cnt_r <= use_cnt_r + STAMP_W'(1);
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.ok             = rsp_r.ok;
  assign out_rsp.hit            = rsp_r.hit;
  assign out_rsp.slot_index     = rsp_r.slot_index;
  assign out_rsp.evicted        = rsp_r.evicted;
  assign out_rsp.evicted_char   = rsp_r.evicted_char;
  assign out_rsp.evicted_width  = rsp_r.evicted_width;
  assign out_rsp.evicted_height = rsp_r.evicted_height;

endmodule
